FILE: hdl/ts2ms_pkg.sv
// ---------------------------------------------------------------------------
// ts2ms_pkg
// Shared types and constants for the time entry to milliseconds converter.
// ---------------------------------------------------------------------------
package ts2ms_pkg;

  localparam int unsigned MINUTE_LIMIT = 71581;

  localparam int MIN_W  = 17;
  localparam int SEC_W  = 7;
  localparam int FRAC_W = 10;
  localparam int CNT_W  = 2;
  localparam int MS_W   = 32;
  localparam int K_W    = 10;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_MIN   = 3'd1,
    PH_SEC   = 3'd2,
    PH_FRAC  = 3'd3,
    PH_TRAIL = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FRAC = 4'b0010,
    S_MIN  = 4'b0100,
    S_MS   = 4'b1000
  } seq_state_t;

  // Constant factor selection for the shared multiply-add unit.
  typedef enum logic [2:0] {
    K_1    = 3'd0,
    K_10   = 3'd1,
    K_100  = 3'd2,
    K_60   = 3'd3,
    K_1000 = 3'd4
  } kfac_t;

  typedef struct packed {
    logic [MS_W-1:0] a;
    kfac_t           k;
    logic [MS_W-1:0] b;
  } mac_req_t;

  function automatic logic [K_W-1:0] kfac_value(kfac_t k);
    logic [K_W-1:0] v;
    unique case (k)
      K_1:     v = K_W'(1);
      K_10:    v = K_W'(10);
      K_100:   v = K_W'(100);
      K_60:    v = K_W'(60);
      K_1000:  v = K_W'(1000);
      default: v = K_W'(1);
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/ts2ms_mac.sv
// ---------------------------------------------------------------------------
// ts2ms_mac
// Shared multiply-add unit: a * k + b, k one of a few constant factors.
// ---------------------------------------------------------------------------
module ts2ms_mac (
  input  ts2ms_pkg::mac_req_t        req,
  output logic [ts2ms_pkg::MS_W-1:0] res
);
  import ts2ms_pkg::*;

  logic [K_W-1:0]      kval;
  logic [MS_W+K_W-1:0] prod;

  always_comb begin
    kval = kfac_value(req.k);
    prod = {{K_W{1'b0}}, req.a} * {{MS_W{1'b0}}, kval};
    res  = prod[MS_W-1:0] + req.b;
  end

endmodule

FILE: hdl/time_string_to_milliseconds.sv
// ---------------------------------------------------------------------------
// time_string_to_milliseconds
// Parses an "m:ss.fff" time entry, one character per transfer, to ms.
// ---------------------------------------------------------------------------
// A character without the last flag is parsed as it is taken, and the block
// stays ready. A character with the last flag is parsed, then the entry makes
// three passes through the shared multiply-add unit (fraction scaling,
// minutes*60+seconds, then *1000+fraction). The result is held in an output
// register, so parsing of the next entry may start while it waits; only a
// second final character stalls until it is taken. Minutes above
// MINUTE_LIMIT, seconds of 60 or more and any syntax error give ok=0 with
// milliseconds zero.
module time_string_to_milliseconds (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_ch,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_ok,
  output logic [ts2ms_pkg::MS_W-1:0] out_milliseconds
);
  import ts2ms_pkg::*;

  seq_state_t          state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [MIN_W-1:0]    min_r, min_nxt;
  logic                big_r, big_nxt;
  logic [SEC_W-1:0]    sec_r, sec_nxt;
  logic [CNT_W-1:0]    sdig_r, sdig_nxt;
  logic [FRAC_W-1:0]   frac_r, frac_nxt;
  logic [CNT_W-1:0]    fdig_r, fdig_nxt;
  logic                err_r, err_nxt;
  logic [FRAC_W-1:0]   fms_r;
  logic [MS_W-1:0]     work_r;
  logic                good_r;
  logic                out_valid_r;
  logic                out_ok_r;
  logic [MS_W-1:0]     out_ms_r;

  logic                in_xfer;
  logic                is_dig, is_ws;
  logic [3:0]          dval;
  logic [MIN_W+3:0]    min_val;
  logic                out_free;
  logic                finish;
  logic                good;
  mac_req_t            mreq;
  logic [MS_W-1:0]     mres;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign finish    = (state_r == S_MS) && out_free;
  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_milliseconds = out_ms_r;

  // Character parse
  always_comb begin
    is_dig  = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
    is_ws   = (in_ch == CH_SPACE) || ((in_ch >= CH_TAB) && (in_ch <= CH_CR));
    dval    = is_dig ? in_ch[3:0] : 4'd0;
    min_val = {1'b0, min_r, 3'b000} + {3'b000, min_r, 1'b0} + (MIN_W+4)'(dval);

    phase_nxt = phase_r;
    min_nxt   = min_r;
    big_nxt   = big_r;
    sec_nxt   = sec_r;
    sdig_nxt  = sdig_r;
    frac_nxt  = frac_r;
    fdig_nxt  = fdig_r;
    err_nxt   = err_r;

    if (!err_r) begin
      unique case (phase_r)
        PH_LEAD: begin
          if (is_ws) begin
          end else if (is_dig) begin
            if (min_val > (MIN_W+4)'(MINUTE_LIMIT)) big_nxt = 1'b1;
            else min_nxt = min_val[MIN_W-1:0];
            phase_nxt = PH_MIN;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_MIN: begin
          if (is_dig) begin
            if (min_val > (MIN_W+4)'(MINUTE_LIMIT)) big_nxt = 1'b1;
            else min_nxt = min_val[MIN_W-1:0];
          end else if (in_ch == CH_COLON) begin
            phase_nxt = PH_SEC;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_SEC: begin
          if (is_dig && sdig_r < CNT_W'(2)) begin
            sec_nxt  = {sec_r[SEC_W-4:0], 3'b000} + {sec_r[SEC_W-2:0], 1'b0}
                       + SEC_W'(dval);
            sdig_nxt = sdig_r + CNT_W'(1);
          end else if (in_ch == CH_DOT && sdig_r != '0) begin
            phase_nxt = PH_FRAC;
          end else if (is_ws && sdig_r != '0) begin
            phase_nxt = PH_TRAIL;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_FRAC: begin
          if (is_dig && fdig_r < CNT_W'(3)) begin
            frac_nxt = {frac_r[FRAC_W-4:0], 3'b000} + {frac_r[FRAC_W-2:0], 1'b0}
                       + FRAC_W'(dval);
            fdig_nxt = fdig_r + CNT_W'(1);
          end else if (is_ws && fdig_r != '0) begin
            phase_nxt = PH_TRAIL;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_TRAIL: begin
          if (!is_ws) err_nxt = 1'b1;
        end
        default: err_nxt = 1'b1;
      endcase
    end
  end

  always_comb begin
    good = !err_r && !big_r && (sec_r < SEC_W'(60)) &&
           ((phase_r == PH_SEC && sdig_r != '0) ||
            (phase_r == PH_FRAC && fdig_r != '0) ||
            (phase_r == PH_TRAIL));
  end

  // Shared unit operand selection
  always_comb begin
    mreq.a = '0;
    mreq.k = K_1;
    mreq.b = '0;
    unique case (state_r)
      S_FRAC: begin
        mreq.a = MS_W'(frac_r);
        if (fdig_r == CNT_W'(1))      mreq.k = K_100;
        else if (fdig_r == CNT_W'(2)) mreq.k = K_10;
        else                          mreq.k = K_1;
      end
      S_MIN: begin
        mreq.a = MS_W'(min_r);
        mreq.k = K_60;
        mreq.b = MS_W'(sec_r);
      end
      S_MS: begin
        mreq.a = work_r;
        mreq.k = K_1000;
        mreq.b = MS_W'(fms_r);
      end
      default: begin
      end
    endcase
  end

  ts2ms_mac u_mac (
    .req (mreq),
    .res (mres)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_xfer && in_last) state_nxt = S_FRAC;
      S_FRAC:  state_nxt = S_MIN;
      S_MIN:   state_nxt = S_MS;
      S_MS:    if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || finish) begin
      phase_r <= PH_LEAD;
      min_r   <= '0;
      big_r   <= 1'b0;
      sec_r   <= '0;
      sdig_r  <= '0;
      frac_r  <= '0;
      fdig_r  <= '0;
      err_r   <= 1'b0;
    end else if (in_xfer) begin
      phase_r <= phase_nxt;
      min_r   <= min_nxt;
      big_r   <= big_nxt;
      sec_r   <= sec_nxt;
      sdig_r  <= sdig_nxt;
      frac_r  <= frac_nxt;
      fdig_r  <= fdig_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      priority if (finish)    out_valid_r <= 1'b1;
      else if (out_ready)     out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FRAC) begin
      fms_r  <= mres[FRAC_W-1:0];
      good_r <= good;
    end
    if (state_r == S_MIN) work_r <= mres;
    if (finish) begin
      out_ok_r <= good_r;
      out_ms_r <= good_r ? mres : '0;
    end
  end

endmodule
